[rtl/core/tfcd_pkg.sv]
// Shared constants and types of the typed frame checksum deframer.
package tfcd_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 32;
   localparam int unsigned MAX_FRAME_LEN   = 32;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 6;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned POS_W  = 5;

   localparam logic [LEN_W-1:0] MOTOR_LEN_RST  = 6'd5;
   localparam logic [LEN_W-1:0] STATUS_LEN_RST = 6'd22;

   // type characters
   localparam logic [BYTE_W-1:0] CHAR_X = 8'h58;
   localparam logic [BYTE_W-1:0] CHAR_Y = 8'h59;
   localparam logic [BYTE_W-1:0] CHAR_L = 8'h4C;
   localparam logic [BYTE_W-1:0] CHAR_F = 8'h46;
   localparam logic [BYTE_W-1:0] CHAR_S = 8'h53;

   // frame kinds
   localparam logic [KIND_W-1:0] KIND_X_MOTOR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_Y_MOTOR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CAM_MOTOR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FLT_MOTOR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd4;

   typedef enum logic [0:0] {
      CSR_MOTOR_LEN  = 1'b0,
      CSR_STATUS_LEN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic take;
      logic emit_read;
      logic emit_next;
   } dp_cmd_type;

   typedef struct packed {
      logic type_hit;
      logic data_last;
      logic sum_match;
      logic emit_last;
   } dp_status_type;

endpackage

[rtl/core/tfcd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tfcd_ram #(
   parameter int unsigned WIDTH = tfcd_pkg::BYTE_W,
   parameter int unsigned DEPTH = tfcd_pkg::MAX_FRAME_LEN
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tfcd_datapath.sv]
// Datapath: length registers, type decode, running sum, byte counter and payload store.
module tfcd_datapath #(
   parameter int unsigned MAX_PAYLOAD = tfcd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [0:0]                  csr_index,
   input  logic [tfcd_pkg::LEN_W-1:0]  csr_data,
   input  logic [tfcd_pkg::BYTE_W-1:0] req_data,
   input  tfcd_pkg::dp_cmd_type        cmd,
   output tfcd_pkg::dp_status_type     status,
   output logic [tfcd_pkg::KIND_W-1:0] rsp_kind,
   output logic [tfcd_pkg::BYTE_W-1:0] rsp_byte,
   output logic [tfcd_pkg::POS_W-1:0]  rsp_pos,
   output logic                        rsp_last
);

   localparam int unsigned DEPTH = (MAX_PAYLOAD < tfcd_pkg::MAX_FRAME_LEN) ?
                                   MAX_PAYLOAD : tfcd_pkg::MAX_FRAME_LEN;
   localparam int unsigned AW = $clog2(DEPTH);
   localparam logic [tfcd_pkg::LEN_W-1:0] LEN_CAP = tfcd_pkg::LEN_W'(DEPTH);

   logic [tfcd_pkg::LEN_W-1:0]  motor_len_ff,  motor_len_in;
   logic [tfcd_pkg::LEN_W-1:0]  status_len_ff, status_len_in;
   logic [tfcd_pkg::LEN_W-1:0]  len_ff,  len_in;
   logic [tfcd_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [tfcd_pkg::BYTE_W-1:0] sum_ff,  sum_in;
   logic [tfcd_pkg::LEN_W-1:0]  cnt_ff,  cnt_in;

   logic                        type_hit;
   logic [tfcd_pkg::KIND_W-1:0] type_kind;
   logic [tfcd_pkg::LEN_W-1:0]  raw_len;
   logic [tfcd_pkg::LEN_W-1:0]  eff_len;
   logic [tfcd_pkg::LEN_W:0]    cnt_inc;

   // configuration writes
   always_comb begin
      motor_len_in  = motor_len_ff;
      status_len_in = status_len_ff;
      if (csr_write) begin
         unique case (tfcd_pkg::csr_index_type'(csr_index))
            tfcd_pkg::CSR_MOTOR_LEN:  motor_len_in  = csr_data;
            tfcd_pkg::CSR_STATUS_LEN: status_len_in = csr_data;
            default: ;
         endcase
      end
   end

   // type character decode
   always_comb begin
      type_hit  = 1'b1;
      type_kind = tfcd_pkg::KIND_X_MOTOR;
      unique case (req_data)
         tfcd_pkg::CHAR_X: type_kind = tfcd_pkg::KIND_X_MOTOR;
         tfcd_pkg::CHAR_Y: type_kind = tfcd_pkg::KIND_Y_MOTOR;
         tfcd_pkg::CHAR_L: type_kind = tfcd_pkg::KIND_CAM_MOTOR;
         tfcd_pkg::CHAR_F: type_kind = tfcd_pkg::KIND_FLT_MOTOR;
         tfcd_pkg::CHAR_S: type_kind = tfcd_pkg::KIND_STATUS;
         default:          type_hit  = 1'b0;
      endcase
   end

   // zero length acts as one, oversize length clamps to the store depth
   always_comb begin
      raw_len = (type_kind == tfcd_pkg::KIND_STATUS) ? status_len_ff : motor_len_ff;
      if (raw_len == '0) begin
         eff_len = tfcd_pkg::LEN_W'(1);
      end else if (raw_len > LEN_CAP) begin
         eff_len = LEN_CAP;
      end else begin
         eff_len = raw_len;
      end
   end

   assign cnt_inc = {1'b0, cnt_ff} + (tfcd_pkg::LEN_W+1)'(1);

   always_comb begin
      status.type_hit  = type_hit;
      status.data_last = cnt_inc >= {1'b0, len_ff};
      status.sum_match = sum_ff == req_data;
      status.emit_last = cnt_inc == {1'b0, len_ff};
   end

   always_comb begin
      len_in  = len_ff;
      kind_in = kind_ff;
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         len_in  = eff_len;
         kind_in = type_kind;
         sum_in  = '0;
         cnt_in  = '0;
      end else if (cmd.take) begin
         sum_in = sum_ff + req_data;
         cnt_in = status.data_last ? '0 : cnt_inc[tfcd_pkg::LEN_W-1:0];
      end else if (cmd.emit_next) begin
         cnt_in = cnt_inc[tfcd_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_len_ff  <= tfcd_pkg::MOTOR_LEN_RST;
         status_len_ff <= tfcd_pkg::STATUS_LEN_RST;
         len_ff        <= '0;
         kind_ff       <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         motor_len_ff  <= motor_len_in;
         status_len_ff <= status_len_in;
         len_ff        <= len_in;
         kind_ff       <= kind_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
      end
   end

   tfcd_ram #(
      .WIDTH (tfcd_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.take),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_data),
      .rd_en   (cmd.emit_read),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rsp_byte)
   );

   assign rsp_kind = kind_ff;
   assign rsp_pos  = cnt_ff[tfcd_pkg::POS_W-1:0];
   assign rsp_last = status.emit_last;

endmodule

[rtl/core/tfcd_ctrl.sv]
// Controller: frame receive phases and drain sequencing of the payload store.
module tfcd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tfcd_pkg::dp_status_type status,
   output tfcd_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DATA,
      ST_SUM,
      ST_READ,
      ST_HOLD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_DATA) || (state_ff == ST_SUM);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.start     = (state_ff == ST_IDLE) && accept && status.type_hit;
      cmd.take      = (state_ff == ST_DATA) && accept;
      cmd.emit_read = (state_ff == ST_READ);
      cmd.emit_next = (state_ff == ST_HOLD) && rsp_ready && !status.emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && status.type_hit) begin
                  state_ff <= ST_DATA;
               end
            end
            ST_DATA: begin
               if (accept && status.data_last) begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               if (accept) begin
                  state_ff <= status.sum_match ? ST_READ : ST_IDLE;
               end
            end
            ST_READ: begin
               state_ff     <= ST_HOLD;
               rsp_valid_ff <= 1'b1;
            end
            ST_HOLD: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= status.emit_last ? ST_IDLE : ST_READ;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   a_valid_only_in_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_HOLD))
      else $error("result valid outside hold state");

   a_no_input_while_emitting: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff)
      else $error("input taken while a result is pending");

   a_mismatch_to_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SUM) && accept && !status.sum_match) |=> (state_ff == ST_IDLE))
      else $error("checksum mismatch did not return to idle");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_HOLD) && rsp_ready && status.emit_last) |=>
         ((state_ff == ST_IDLE) && !rsp_valid_ff))
      else $error("frame drain did not end after last word");

endmodule

[rtl/core/typed_frame_checksum_deframer.sv]
// Top level of the typed frame checksum deframer: ports, controller and datapath.
// After the checksum word is taken, the first payload word is offered once its store read is registered.
// Throughput: one received word per cycle while a frame arrives; each payload word of a verified
// frame is drained as a registered store read, then an output hold until it is taken,
// and no input word is taken until the last payload word has been accepted.
// Reset (synchronous, active high): back to idle, lengths restored to 5 and 22; store kept.
module typed_frame_checksum_deframer #(
   parameter int unsigned MAX_PAYLOAD = tfcd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,

   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [5:0]  csr_data,

   // received words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte

   // verified payload words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [12:8] byte_position, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] frame_kind
   output logic        rsp_tlast    // frame_end
);

   tfcd_pkg::dp_cmd_type    cmd;
   tfcd_pkg::dp_status_type status;

   logic [tfcd_pkg::KIND_W-1:0] rsp_kind;
   logic [tfcd_pkg::BYTE_W-1:0] rsp_byte;
   logic [tfcd_pkg::POS_W-1:0]  rsp_pos;
   logic                        rsp_last;

   // the frame length is latched at the type word, so take every write at once
   assign csr_ready = 1'b1;

   tfcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tfcd_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_kind  (rsp_kind),
      .rsp_byte  (rsp_byte),
      .rsp_pos   (rsp_pos),
      .rsp_last  (rsp_last)
   );

   // pack the result word: payload byte low, position above, zero fill to 16 bits
   assign rsp_tdata = {3'b000, rsp_pos, rsp_byte};
   assign rsp_tuser = rsp_kind;
   assign rsp_tlast = rsp_last;

endmodule

[dv/tb_typed_frame_checksum_deframer.sv]
// Testbench of the typed frame checksum deframer: framed byte stream checked against a predictor.
module tb_typed_frame_checksum_deframer;

   localparam int CLOCK_HALF    = 5;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_WORDS  = 150;
   localparam int PHASE_WORDS   = 40;
   localparam int REPORT_LIMIT  = 10;

   // ways a random frame may be spoilt
   localparam int FLAW_NONE  = 0;
   localparam int FLAW_SUM   = 1;
   localparam int FLAW_SHORT = 2;

   localparam logic [tfcd_pkg::BYTE_W-1:0] TYPE_CHARS [5] = '{
      tfcd_pkg::CHAR_X, tfcd_pkg::CHAR_Y, tfcd_pkg::CHAR_L, tfcd_pkg::CHAR_F, tfcd_pkg::CHAR_S
   };

   typedef logic [tfcd_pkg::BYTE_W-1:0] byte_list_type[$];

   typedef enum logic [1:0] {
      HUNT        = 2'd0,
      IN_PAYLOAD  = 2'd1,
      AT_CHECKSUM = 2'd2
   } rx_phase_type;

   typedef struct packed {
      logic [tfcd_pkg::KIND_W-1:0] kind;
      logic [tfcd_pkg::BYTE_W-1:0] data;
      logic [tfcd_pkg::POS_W-1:0]  pos;
      logic                        last;
   } payload_word_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   tfcd_pkg::csr_index_type     csr_index  = tfcd_pkg::CSR_MOTOR_LEN;
   logic [tfcd_pkg::LEN_W-1:0]  csr_data   = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [7:0]                  req_tdata  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [15:0]                 rsp_tdata;
   logic [2:0]                  rsp_tuser;
   logic                        rsp_tlast;

   // bytes still to be offered, and payload words the predictor says must come out
   byte_list_type               rx_words;
   payload_word_type            payload_due[$];

   // predictor state and its copy of the length registers
   rx_phase_type                pk_phase = HUNT;
   logic [tfcd_pkg::KIND_W-1:0] pk_kind  = '0;
   int unsigned                 pk_len   = 0;
   int unsigned                 pk_taken = 0;
   logic [tfcd_pkg::BYTE_W-1:0] pk_sum   = '0;
   logic [tfcd_pkg::BYTE_W-1:0] pk_store [tfcd_pkg::MAX_FRAME_LEN];
   logic [tfcd_pkg::LEN_W-1:0]  motor_len_copy  = tfcd_pkg::MOTOR_LEN_RST;
   logic [tfcd_pkg::LEN_W-1:0]  status_len_copy = tfcd_pkg::STATUS_LEN_RST;

   bit                          quiet_tail = 1'b0;
   int                          mismatches = 0;
   int                          req_gap    = 0;
   int                          rsp_stall  = 0;
   int                          cycles     = 0;
   payload_word_type            seen_due;

   typed_frame_checksum_deframer DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // A zero register acts as one; anything beyond the store is clipped to it.
   function automatic int unsigned frame_len_of(input logic [tfcd_pkg::LEN_W-1:0] reg_value);
      int unsigned n;
      n = reg_value;
      if (n == 0) n = 1;
      if (n > tfcd_pkg::MAX_FRAME_LEN) n = tfcd_pkg::MAX_FRAME_LEN;
      return n;
   endfunction

   function automatic void open_frame(input logic [tfcd_pkg::KIND_W-1:0] kind,
                                      input int unsigned len);
      pk_kind  = kind;
      pk_len   = len;
      pk_taken = 0;
      pk_sum   = '0;
      pk_phase = IN_PAYLOAD;
   endfunction

   // Advance the predictor by one received word; queue the payload of a verified frame.
   function automatic void deframe_word(input logic [tfcd_pkg::BYTE_W-1:0] b);
      payload_word_type w;
      case (pk_phase)
         IN_PAYLOAD: begin
            pk_store[pk_taken] = b;
            pk_sum = pk_sum + b;
            pk_taken++;
            if (pk_taken >= pk_len) begin
               pk_taken = 0;
               pk_phase = AT_CHECKSUM;
            end
         end
         AT_CHECKSUM: begin
            // unsigned compare: checksum words of 128 and up are valid
            if (pk_sum == b) begin
               for (int unsigned i = 0; i < pk_len; i++) begin
                  w.kind = pk_kind;
                  w.data = pk_store[i];
                  w.pos  = tfcd_pkg::POS_W'(i);
                  w.last = (i + 1 == pk_len);
                  payload_due.push_back(w);
               end
               pk_len = 0;
            end
            pk_phase = HUNT;
         end
         default: begin
            // hunting: anything but a type character is dropped
            pk_phase = HUNT;
            case (b)
               tfcd_pkg::CHAR_X:
                  open_frame(tfcd_pkg::KIND_X_MOTOR, frame_len_of(motor_len_copy));
               tfcd_pkg::CHAR_Y:
                  open_frame(tfcd_pkg::KIND_Y_MOTOR, frame_len_of(motor_len_copy));
               tfcd_pkg::CHAR_L:
                  open_frame(tfcd_pkg::KIND_CAM_MOTOR, frame_len_of(motor_len_copy));
               tfcd_pkg::CHAR_F:
                  open_frame(tfcd_pkg::KIND_FLT_MOTOR, frame_len_of(motor_len_copy));
               tfcd_pkg::CHAR_S:
                  open_frame(tfcd_pkg::KIND_STATUS, frame_len_of(status_len_copy));
               default: ;
            endcase
         end
      endcase
   endfunction

   function automatic void flag_error(input string msg);
      if (mismatches < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
      mismatches++;
   endfunction

   function automatic void send_frame(input logic [tfcd_pkg::BYTE_W-1:0] tchar,
                                      input byte_list_type body,
                                      input logic [tfcd_pkg::BYTE_W-1:0] csum);
      rx_words.push_back(tchar);
      foreach (body[i]) rx_words.push_back(body[i]);
      rx_words.push_back(csum);
   endfunction

   // Queue one frame of random payload; return the number of words it takes.
   function automatic int random_frame(input logic [tfcd_pkg::BYTE_W-1:0] tchar,
                                       input int unsigned len, input int flaw);
      byte_list_type               body;
      logic [tfcd_pkg::BYTE_W-1:0] total;
      int unsigned                 keep;
      total = '0;
      keep  = len;
      if (flaw == FLAW_SHORT) keep = $urandom_range(0, len - 1);
      for (int unsigned i = 0; i < keep; i++) begin
         body.push_back(tfcd_pkg::BYTE_W'($urandom_range(0, 255)));
         total = total + body[i];
      end
      if (flaw == FLAW_SHORT) begin
         // broken off: the next words land in this frame's payload
         rx_words.push_back(tchar);
         foreach (body[i]) rx_words.push_back(body[i]);
         return keep + 1;
      end
      if (flaw == FLAW_SUM) total = total + tfcd_pkg::BYTE_W'($urandom_range(1, 255));
      send_frame(tchar, body, total);
      return len + 2;
   endfunction

   // Hold until every queued word is taken and every predicted word is out, then settle.
   task automatic settle();
      while (rx_words.size() != 0 || payload_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_len(input tfcd_pkg::csr_index_type idx,
                            input logic [tfcd_pkg::LEN_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tfcd_pkg::CSR_MOTOR_LEN) motor_len_copy = value;
      else status_len_copy = value;
   endtask

   // Word driver: offer queued bytes, holding each until taken, with random gap bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_word(req_tdata);
            void'(rx_words.pop_front());
         end
         // a word on offer but not taken stays as it is
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
               req_gap = $urandom_range(0, 15);
               req_tvalid <= 1'b0;
            end else if (rx_words.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= rx_words[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: stall in random bursts, never during the quiet tail.
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         rsp_stall = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: compare each taken payload word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (payload_due.size() == 0) begin
            flag_error($sformatf("unexpected word: tdata %h tuser %0d tlast %b",
                                 rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            seen_due = payload_due.pop_front();
            if (rsp_tuser !== seen_due.kind)
               flag_error($sformatf("frame_kind: expected %0d, got %0d",
                                    seen_due.kind, rsp_tuser));
            if (rsp_tdata[7:0] !== seen_due.data)
               flag_error($sformatf("payload_byte: expected %h, got %h",
                                    seen_due.data, rsp_tdata[7:0]));
            if (rsp_tdata[12:8] !== seen_due.pos)
               flag_error($sformatf("byte_position: expected %0d, got %0d",
                                    seen_due.pos, rsp_tdata[12:8]));
            if (rsp_tlast !== seen_due.last)
               flag_error($sformatf("frame_end: expected %b, got %b",
                                    seen_due.last, rsp_tlast));
            if (rsp_tdata[15:13] !== 3'b000)
               flag_error($sformatf("tdata padding: expected 0, got %b", rsp_tdata[15:13]));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      byte_list_type               body;
      logic [tfcd_pkg::BYTE_W-1:0] tchar;
      logic [tfcd_pkg::BYTE_W-1:0] total;
      int unsigned                 spent;
      int unsigned                 phase_spent;
      int unsigned                 len;
      int                          pick;

      spent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // stray words while hunting: both extremes and a lowercase letter are dropped
      rx_words.push_back(8'h00);
      rx_words.push_back(8'hFF);
      rx_words.push_back(8'h78);
      // X frame at reset length whose checksum has its top bit set
      body = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
      send_frame(tfcd_pkg::CHAR_X, body, 8'hFF);
      // Y frame with a wrong checksum: nothing comes out
      body = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
      send_frame(tfcd_pkg::CHAR_Y, body, 8'h00);
      settle();

      // zero length acts as one
      write_len(tfcd_pkg::CSR_MOTOR_LEN, 6'd0);
      write_len(tfcd_pkg::CSR_STATUS_LEN, 6'd1);
      body = '{8'h80};
      send_frame(tfcd_pkg::CHAR_L, body, 8'h80);
      body = '{8'h00};
      send_frame(tfcd_pkg::CHAR_F, body, 8'h00);
      body = '{8'hFF};
      send_frame(tfcd_pkg::CHAR_S, body, 8'hFF);
      settle();

      // largest frames: a register beyond the store is clipped to it
      write_len(tfcd_pkg::CSR_MOTOR_LEN, 6'd32);
      write_len(tfcd_pkg::CSR_STATUS_LEN, 6'd63);
      void'(random_frame(tfcd_pkg::CHAR_S, tfcd_pkg::MAX_FRAME_LEN, FLAW_NONE));
      void'(random_frame(tfcd_pkg::CHAR_X, tfcd_pkg::MAX_FRAME_LEN, FLAW_NONE));
      settle();

      // length latched at the type word: rewrite the register mid-frame
      body.delete();
      total = '0;
      for (int i = 0; i < tfcd_pkg::MAX_FRAME_LEN; i++) begin
         body.push_back(tfcd_pkg::BYTE_W'($urandom_range(0, 255)));
         total = total + body[i];
      end
      rx_words.push_back(tfcd_pkg::CHAR_S);
      for (int i = 0; i < 10; i++) rx_words.push_back(body[i]);
      settle();
      write_len(tfcd_pkg::CSR_STATUS_LEN, 6'd3);
      for (int i = 10; i < tfcd_pkg::MAX_FRAME_LEN; i++) rx_words.push_back(body[i]);
      rx_words.push_back(total);
      void'(random_frame(tfcd_pkg::CHAR_S, 3, FLAW_NONE));
      settle();

      // random phases: mostly short lengths, now and then any register value
      while (spent < RANDOM_WORDS) begin
         if (spent + PHASE_WORDS + 10 >= RANDOM_WORDS) quiet_tail = 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            write_len(tfcd_pkg::CSR_MOTOR_LEN, tfcd_pkg::LEN_W'($urandom_range(0, 63)));
         end else begin
            write_len(tfcd_pkg::CSR_MOTOR_LEN, tfcd_pkg::LEN_W'($urandom_range(1, 6)));
         end
         if ($urandom_range(0, 3) == 0) begin
            write_len(tfcd_pkg::CSR_STATUS_LEN, tfcd_pkg::LEN_W'($urandom_range(0, 63)));
         end else begin
            write_len(tfcd_pkg::CSR_STATUS_LEN, tfcd_pkg::LEN_W'($urandom_range(1, 8)));
         end
         phase_spent = 0;
         while (phase_spent < PHASE_WORDS && spent + phase_spent < RANDOM_WORDS) begin
            pick  = $urandom_range(0, 11);
            tchar = TYPE_CHARS[$urandom_range(0, 4)];
            len   = (tchar == tfcd_pkg::CHAR_S) ? frame_len_of(status_len_copy)
                                                : frame_len_of(motor_len_copy);
            if (pick == 0) begin
               // noise while hunting: dropped, so not counted
               rx_words.push_back(tfcd_pkg::BYTE_W'($urandom_range(0, 255)));
            end else if (pick == 1) begin
               phase_spent += random_frame(tchar, len, FLAW_SHORT);
            end else if (pick == 2) begin
               phase_spent += random_frame(tchar, len, FLAW_SUM);
            end else begin
               phase_spent += random_frame(tchar, len, FLAW_NONE);
            end
         end
         spent += phase_spent;
         settle();
      end

      quiet_tail = 1'b1;
      settle();
      if (mismatches == 0 && payload_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/tfcd_pkg.sv
rtl/core/tfcd_ram.sv
rtl/core/tfcd_datapath.sv
rtl/core/tfcd_ctrl.sv
rtl/core/typed_frame_checksum_deframer.sv
dv/tb_typed_frame_checksum_deframer.sv
